>>> rtl/lgg_pkg.sv
// ----------------------------------------------------------------------------
// Linear gradient generator package
// Shared widths, register indexes, control and status types, helpers.
// ----------------------------------------------------------------------------
package lgg_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int FRAC_W    = 16;
    localparam int CH_W      = 8;
    localparam int COLOR_W   = 3 * CH_W;
    localparam int NUM_CH    = 3;
    localparam int SEL_W     = 2;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int Q_W       = FRAC_W + 1;
    localparam int DIFF_W    = CH_W + 1;
    localparam int PROD_W    = Q_W + 1 + DIFF_W;
    localparam int STEP_W    = 25;
    localparam int ACC_W     = 24;
    localparam int SUM_W     = ACC_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_MODE = 3'd4;

    typedef struct packed {
        logic             latch;
        logic             advance;
        logic             mul_en;
        logic [SEL_W-1:0] mul_sel;
        logic             load;
    } lgg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic frame_end;
    } lgg_status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        begin
            r = d;
            if (d == '0)
            begin
                r = DIM_W'(1);
            end
            else if (d > DIM_W'(MAX_DIM))
            begin
                r = DIM_W'(MAX_DIM);
            end
            return r;
        end
    endfunction

endpackage

>>> rtl/lgg_div.sv
// ----------------------------------------------------------------------------
// Step divider
// Restoring divider forming 65536 / L, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lgg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lgg_pkg::DIM_W-1:0]  divisor,
    output logic [lgg_pkg::Q_W-1:0]    quotient,
    output logic                       done
);

    localparam int CNT_W = $clog2(lgg_pkg::Q_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [lgg_pkg::DIM_W-1:0] rem_reg, rem_next;
    logic [lgg_pkg::DIM_W-1:0] dvs_reg, dvs_next;
    logic [lgg_pkg::Q_W-1:0]   q_reg, q_next;
    logic [lgg_pkg::DIM_W:0]   trial;
    logic                      fits;

    always_comb
    begin
        trial = {rem_reg, (cnt_reg == CNT_W'(lgg_pkg::Q_W - 1))};
        fits  = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(lgg_pkg::Q_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[lgg_pkg::Q_W-2:0], fits};
            if (fits)
            begin
                rem_next = lgg_pkg::DIM_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[lgg_pkg::DIM_W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

>>> rtl/lgg_datapath.sv
// ----------------------------------------------------------------------------
// Gradient datapath
// Configuration registers, frame latches, step multiplier, accumulators
// and pixel counters.
// ----------------------------------------------------------------------------
module lgg_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lgg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgg_pkg::CFG_W-1:0]      cfg_data,
    input  lgg_pkg::lgg_cmd_t              cmd,
    output lgg_pkg::lgg_status_t           status,
    output logic [lgg_pkg::CH_W-1:0]       red,
    output logic [lgg_pkg::CH_W-1:0]       green,
    output logic [lgg_pkg::CH_W-1:0]       blue,
    output logic [lgg_pkg::POS_W-1:0]      column,
    output logic [lgg_pkg::POS_W-1:0]      row
);

    localparam int CH_W   = lgg_pkg::CH_W;
    localparam int DIM_W  = lgg_pkg::DIM_W;
    localparam int POS_W  = lgg_pkg::POS_W;
    localparam int STEP_W = lgg_pkg::STEP_W;
    localparam int ACC_W  = lgg_pkg::ACC_W;
    localparam int SUM_W  = lgg_pkg::SUM_W;
    localparam int DIFF_W = lgg_pkg::DIFF_W;
    localparam int PROD_W = lgg_pkg::PROD_W;
    localparam int FRAC_W = lgg_pkg::FRAC_W;

    logic [lgg_pkg::COLOR_W-1:0] start_color_reg;
    logic [lgg_pkg::COLOR_W-1:0] end_color_reg;
    logic [DIM_W-1:0]            width_cfg_reg;
    logic [DIM_W-1:0]            height_cfg_reg;
    logic                        vertical_cfg_reg;

    logic [DIM_W-1:0]         width_reg, width_next;
    logic [DIM_W-1:0]         height_reg, height_next;
    logic                     vertical_reg, vertical_next;
    logic [CH_W-1:0]          start_reg [lgg_pkg::NUM_CH];
    logic [CH_W-1:0]          start_next [lgg_pkg::NUM_CH];
    logic signed [DIFF_W-1:0] diff_reg [lgg_pkg::NUM_CH];
    logic signed [DIFF_W-1:0] diff_next [lgg_pkg::NUM_CH];
    logic signed [STEP_W-1:0] step_reg [lgg_pkg::NUM_CH];
    logic signed [STEP_W-1:0] step_next [lgg_pkg::NUM_CH];
    logic [ACC_W-1:0]         acc_reg [lgg_pkg::NUM_CH];
    logic [ACC_W-1:0]         acc_next [lgg_pkg::NUM_CH];
    logic [POS_W-1:0]         col_reg, col_next;
    logic [POS_W-1:0]         row_reg, row_next;

    logic [DIM_W-1:0]          width_clamped;
    logic [DIM_W-1:0]          height_clamped;
    logic [lgg_pkg::Q_W-1:0]   quotient;
    logic                      div_done;
    logic signed [PROD_W-1:0]  product;
    logic signed [SUM_W-1:0]   base_sum [lgg_pkg::NUM_CH];
    logic signed [SUM_W-1:0]   step_sum [lgg_pkg::NUM_CH];
    logic [DIM_W-1:0]          col_inc;
    logic [DIM_W-1:0]          row_inc;

    assign width_clamped  = lgg_pkg::clamp_dim(width_cfg_reg);
    assign height_clamped = lgg_pkg::clamp_dim(height_cfg_reg);

    lgg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.latch),
        .divisor  (vertical_cfg_reg ? height_clamped : width_clamped),
        .quotient (quotient),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_color_reg  <= '0;
            end_color_reg    <= '0;
            width_cfg_reg    <= DIM_W'(1);
            height_cfg_reg   <= DIM_W'(1);
            vertical_cfg_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lgg_pkg::REG_START_COLOR:   start_color_reg  <= cfg_data;
                lgg_pkg::REG_END_COLOR:     end_color_reg    <= cfg_data;
                lgg_pkg::REG_IMAGE_WIDTH:   width_cfg_reg    <= cfg_data[DIM_W-1:0];
                lgg_pkg::REG_IMAGE_HEIGHT:  height_cfg_reg   <= cfg_data[DIM_W-1:0];
                lgg_pkg::REG_VERTICAL_MODE: vertical_cfg_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign product = $signed({1'b0, quotient}) * diff_reg[cmd.mul_sel];
    assign col_inc = {1'b0, col_reg} + DIM_W'(1);
    assign row_inc = {1'b0, row_reg} + DIM_W'(1);

    always_comb
    begin
        for (int c = 0; c < lgg_pkg::NUM_CH; c++)
        begin
            base_sum[c] = $signed({2'b00, start_reg[c], {FRAC_W{1'b0}}})
                        + {{(SUM_W-STEP_W){step_reg[c][STEP_W-1]}}, step_reg[c]};
            step_sum[c] = $signed({2'b00, acc_reg[c]})
                        + {{(SUM_W-STEP_W){step_reg[c][STEP_W-1]}}, step_reg[c]};
        end

        width_next    = width_reg;
        height_next   = height_reg;
        vertical_next = vertical_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        for (int c = 0; c < lgg_pkg::NUM_CH; c++)
        begin
            start_next[c] = start_reg[c];
            diff_next[c]  = diff_reg[c];
            step_next[c]  = step_reg[c];
            acc_next[c]   = acc_reg[c];
        end

        if (cmd.latch)
        begin
            width_next    = width_clamped;
            height_next   = height_clamped;
            vertical_next = vertical_cfg_reg;
            for (int c = 0; c < lgg_pkg::NUM_CH; c++)
            begin
                start_next[c] = start_color_reg[(2-c)*CH_W +: CH_W];
                diff_next[c]  = $signed({1'b0, end_color_reg[(2-c)*CH_W +: CH_W]})
                              - $signed({1'b0, start_color_reg[(2-c)*CH_W +: CH_W]});
            end
        end

        if (cmd.mul_en)
        begin
            step_next[cmd.mul_sel] = product[STEP_W-1:0];
        end

        if (cmd.load)
        begin
            col_next = '0;
            row_next = '0;
            for (int c = 0; c < lgg_pkg::NUM_CH; c++)
            begin
                acc_next[c] = base_sum[c][ACC_W-1:0];
            end
        end
        else if (cmd.advance)
        begin
            if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = row_inc[POS_W-1:0];
                for (int c = 0; c < lgg_pkg::NUM_CH; c++)
                begin
                    acc_next[c] = vertical_reg ? step_sum[c][ACC_W-1:0]
                                               : base_sum[c][ACC_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
                if (!vertical_reg)
                begin
                    for (int c = 0; c < lgg_pkg::NUM_CH; c++)
                    begin
                        acc_next[c] = step_sum[c][ACC_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
            vertical_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            for (int c = 0; c < lgg_pkg::NUM_CH; c++)
            begin
                start_reg[c] <= '0;
                diff_reg[c]  <= '0;
                step_reg[c]  <= '0;
                acc_reg[c]   <= '0;
            end
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            vertical_reg <= vertical_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            for (int c = 0; c < lgg_pkg::NUM_CH; c++)
            begin
                start_reg[c] <= start_next[c];
                diff_reg[c]  <= diff_next[c];
                step_reg[c]  <= step_next[c];
                acc_reg[c]   <= acc_next[c];
            end
        end
    end

    assign status.div_done  = div_done;
    assign status.frame_end = (col_inc == width_reg) && (row_inc == height_reg);

    assign red    = acc_reg[0][FRAC_W +: CH_W];
    assign green  = acc_reg[1][FRAC_W +: CH_W];
    assign blue   = acc_reg[2][FRAC_W +: CH_W];
    assign column = col_reg;
    assign row    = row_reg;

endmodule

>>> rtl/lgg_ctrl.sv
// ----------------------------------------------------------------------------
// Gradient controller
// Sequences frame start (divide, multiply, load) and the item handshake.
// ----------------------------------------------------------------------------
module lgg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  lgg_pkg::lgg_status_t status,
    output lgg_pkg::lgg_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    localparam int SEL_W = lgg_pkg::SEL_W;

    logic [1:0]       state_reg, state_next;
    logic [SEL_W-1:0] ch_reg, ch_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             begin_frame;

    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept      = in_valid && in_ready;
    assign begin_frame = restart || status.frame_end;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_sel    = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (begin_frame)
                    begin
                        cmd.latch  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        cmd.advance    = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    ch_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (ch_reg == SEL_W'(lgg_pkg::NUM_CH - 1))
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    ch_next = ch_reg + SEL_W'(1);
                end
            end
            S_LOAD:
            begin
                cmd.load       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_begin_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept && begin_frame |=> state_reg == S_DIV)
        else $error("frame start did not enter divide");

    a_advance_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !begin_frame |=> out_valid_reg)
        else $error("advance item produced no pixel");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_load_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg && state_reg == S_IDLE)
        else $error("load did not present first pixel");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !in_ready)
        else $error("item taken while pixel still pending");

endmodule

>>> rtl/linear_gradient_generator.sv
// ----------------------------------------------------------------------------
// Linear gradient generator
// Emits one pixel of a linear colour gradient frame, in raster order, per item.
// An advancing item gives its pixel in the cycle after acceptance; throughput 1/cycle while
// out_ready stays high. Frame start (restart, or first item after a frame end) holds off items
// while the bit-serial divider, then the shared step multiplier (one channel at a time) run.
// Reset (asynchronous, active low) clears config to start 0, end 0, size 1x1, horizontal.
// ----------------------------------------------------------------------------
module linear_gradient_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lgg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgg_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           restart,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lgg_pkg::CH_W-1:0]       red,
    output logic [lgg_pkg::CH_W-1:0]       green,
    output logic [lgg_pkg::CH_W-1:0]       blue,
    output logic [lgg_pkg::POS_W-1:0]      column,
    output logic [lgg_pkg::POS_W-1:0]      row,
    output logic                           frame_end
);

    lgg_pkg::lgg_cmd_t    cmd;
    lgg_pkg::lgg_status_t status;

    lgg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lgg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .column    (column),
        .row       (row)
    );

    assign frame_end = status.frame_end;

endmodule

>>> sim/gradient_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient pixel checker
// Watches the register port and both item channels of the gradient generator.
// Keeps its own copy of the registers and the frame state, works out the
// pixel that each accepted item must give, and compares every accepted pixel
// against the oldest expected one. Mismatches and the number of pixels still
// expected are handed to the testbench top.
// ----------------------------------------------------------------------------
module gradient_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [lgg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lgg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          restart,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [lgg_pkg::CH_W-1:0]      red,
    input  logic [lgg_pkg::CH_W-1:0]      green,
    input  logic [lgg_pkg::CH_W-1:0]      blue,
    input  logic [lgg_pkg::POS_W-1:0]     column,
    input  logic [lgg_pkg::POS_W-1:0]     row,
    input  logic                          frame_end,
    output int                            mismatches,
    output int                            outstanding
);

    localparam int CH_W    = lgg_pkg::CH_W;
    localparam int POS_W   = lgg_pkg::POS_W;
    localparam int COLOR_W = lgg_pkg::COLOR_W;
    localparam int DIM_W   = lgg_pkg::DIM_W;
    localparam int NUM_CH  = lgg_pkg::NUM_CH;
    localparam int FRAC_W  = lgg_pkg::FRAC_W;
    localparam int MAX_DIM = lgg_pkg::MAX_DIM;

    typedef struct packed {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } pixel_t;

    pixel_t expected_pixels[$];

    logic [COLOR_W-1:0] start_reg;
    logic [COLOR_W-1:0] end_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               vert_reg;

    int   frame_w;
    int   frame_h;
    logic frame_vert;
    logic frame_open;
    int   base_fx[NUM_CH];
    int   step_fx[NUM_CH];
    int   acc_fx[NUM_CH];
    int   col_n;
    int   row_n;
    int   errors;

    function automatic int dim_limit(input logic [DIM_W-1:0] d);
        int v;
        begin
            v = int'(d);
            if (v == 0)
            begin
                v = 1;
            end
            else if (v > MAX_DIM)
            begin
                v = MAX_DIM;
            end
            return v;
        end
    endfunction

    function automatic int channel(input logic [COLOR_W-1:0] colour, input int c);
        begin
            return int'((colour >> (16 - 8 * c)) & 24'hFF);
        end
    endfunction

    task automatic predict_pixel(input logic rs, output pixel_t px);
        int          q;
        int          s;
        logic [31:0] a[NUM_CH];
        begin
            if (rs || !frame_open)
            begin
                frame_w    = dim_limit(width_reg);
                frame_h    = dim_limit(height_reg);
                frame_vert = vert_reg;
                q = 65536 / (frame_vert ? frame_h : frame_w);
                for (int c = 0; c < NUM_CH; c++)
                begin
                    s          = channel(start_reg, c);
                    base_fx[c] = s * 65536;
                    step_fx[c] = q * (channel(end_reg, c) - s);
                    acc_fx[c]  = base_fx[c] + step_fx[c];
                end
                col_n      = 0;
                row_n      = 0;
                frame_open = 1'b1;
            end
            else
            begin
                col_n++;
                if (col_n >= frame_w)
                begin
                    col_n = 0;
                    row_n++;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        if (frame_vert)
                        begin
                            acc_fx[c] = acc_fx[c] + step_fx[c];
                        end
                        else
                        begin
                            acc_fx[c] = base_fx[c] + step_fx[c];
                        end
                    end
                end
                else if (!frame_vert)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        acc_fx[c] = acc_fx[c] + step_fx[c];
                    end
                end
            end
            for (int c = 0; c < NUM_CH; c++)
            begin
                a[c] = acc_fx[c];
            end
            px.red   = a[0][FRAC_W +: CH_W];
            px.green = a[1][FRAC_W +: CH_W];
            px.blue  = a[2][FRAC_W +: CH_W];
            px.x     = POS_W'(col_n);
            px.y     = POS_W'(row_n);
            px.last  = (col_n + 1 == frame_w) && (row_n + 1 == frame_h);
            if (px.last)
            begin
                frame_open = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            start_reg  = '0;
            end_reg    = '0;
            width_reg  = DIM_W'(1);
            height_reg = DIM_W'(1);
            vert_reg   = 1'b0;
            frame_w    = 1;
            frame_h    = 1;
            frame_vert = 1'b0;
            frame_open = 1'b0;
            col_n      = 0;
            row_n      = 0;
            errors     = 0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                base_fx[c] = 0;
                step_fx[c] = 0;
                acc_fx[c]  = 0;
            end
            expected_pixels.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    lgg_pkg::REG_START_COLOR:   start_reg  = cfg_data[COLOR_W-1:0];
                    lgg_pkg::REG_END_COLOR:     end_reg    = cfg_data[COLOR_W-1:0];
                    lgg_pkg::REG_IMAGE_WIDTH:   width_reg  = cfg_data[DIM_W-1:0];
                    lgg_pkg::REG_IMAGE_HEIGHT:  height_reg = cfg_data[DIM_W-1:0];
                    lgg_pkg::REG_VERTICAL_MODE: vert_reg   = cfg_data[0];
                    default: ;
                endcase
            end
            // check the outgoing pixel before queueing a new expectation
            if (out_valid && out_ready)
            begin
                got = '{red, green, blue, column, row, frame_end};
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected pixel r=%0d g=%0d b=%0d x=%0d y=%0d end=%0b",
                                 got.red, got.green, got.blue, got.x, got.y, got.last);
                    end
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.x !== want.x
                        || got.y !== want.y || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("expected r=%0d g=%0d b=%0d x=%0d y=%0d end=%0b",
                                     want.red, want.green, want.blue,
                                     want.x, want.y, want.last);
                            $display("actual   r=%0d g=%0d b=%0d x=%0d y=%0d end=%0b",
                                     got.red, got.green, got.blue,
                                     got.x, got.y, got.last);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_pixel(restart, want);
                expected_pixels.push_back(want);
            end
            outstanding <= expected_pixels.size();
            mismatches  <= errors;
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear gradient generator testbench
// Drives the register port and the item channel of the gradient generator:
// a short directed run over colour and size extremes, mid-frame register
// changes and frames started without a restart, then random frame sequences
// under three idling regimes. The checker beside the block predicts and
// compares every pixel; the verdict follows its mismatch count.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 650;
    localparam int MAX_RUN      = 48;
    localparam int COLOR_W      = lgg_pkg::COLOR_W;
    localparam int DIM_W        = lgg_pkg::DIM_W;
    localparam int CFG_W        = lgg_pkg::CFG_W;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [lgg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]              cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          restart;
    logic                          out_valid;
    logic                          out_ready;
    logic [lgg_pkg::CH_W-1:0]      red;
    logic [lgg_pkg::CH_W-1:0]      green;
    logic [lgg_pkg::CH_W-1:0]      blue;
    logic [lgg_pkg::POS_W-1:0]     column;
    logic [lgg_pkg::POS_W-1:0]     row;
    logic                          frame_end;

    int mismatches;
    int outstanding;
    int cycles = 0;
    int send_idle;
    int recv_idle;
    int sent;

    linear_gradient_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .column    (column),
        .row       (row),
        .frame_end (frame_end)
    );

    gradient_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .column      (column),
        .row         (row),
        .frame_end   (frame_end),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_pixel(input logic rs);
        begin
            if ($urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(99) < send_idle);
            end
            in_valid <= 1'b1;
            restart  <= rs;
            do
                @(posedge clk);
            while (!in_ready);
            sent++;
        end
    endtask

    task automatic drain();
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (outstanding != 0);
        end
    endtask

    task automatic set_frame(input logic [COLOR_W-1:0] s, input logic [COLOR_W-1:0] e,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic v);
        begin
            cfg_write <= 1'b1;
            cfg_index <= lgg_pkg::REG_START_COLOR;
            cfg_data  <= CFG_W'(s);
            @(posedge clk);
            cfg_index <= lgg_pkg::REG_END_COLOR;
            cfg_data  <= CFG_W'(e);
            @(posedge clk);
            cfg_index <= lgg_pkg::REG_IMAGE_WIDTH;
            cfg_data  <= CFG_W'(w);
            @(posedge clk);
            cfg_index <= lgg_pkg::REG_IMAGE_HEIGHT;
            cfg_data  <= CFG_W'(h);
            @(posedge clk);
            cfg_index <= lgg_pkg::REG_VERTICAL_MODE;
            cfg_data  <= CFG_W'(v);
            @(posedge clk);
            cfg_write <= 1'b0;
        end
    endtask

    function automatic logic [COLOR_W-1:0] pick_colour();
        int sel;
        begin
            sel = $urandom_range(7);
            if (sel == 0)
            begin
                return '0;
            end
            else if (sel == 1)
            begin
                return '1;
            end
            return COLOR_W'($urandom());
        end
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input int hi);
        begin
            if ($urandom_range(9) == 0)
            begin
                return DIM_W'($urandom_range(8191));
            end
            return DIM_W'($urandom_range(1, hi));
        end
    endfunction

    task automatic random_run();
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               pixels;
        int               n;
        logic             noisy;
        begin
            w = pick_dim(8);
            h = pick_dim(6);
            drain();
            set_frame(pick_colour(), pick_colour(), w, h, 1'($urandom_range(1)));
            pixels = (w == 0 ? 1 : int'(w)) * (h == 0 ? 1 : int'(h));
            n = pixels * $urandom_range(1, 3) + $urandom_range(2);
            if (n > MAX_RUN)
            begin
                n = $urandom_range(5, MAX_RUN);
            end
            noisy = ($urandom_range(7) == 0);
            for (int i = 0; i < n; i++)
            begin
                if (noisy)
                begin
                    push_pixel(1'($urandom_range(1)));
                end
                else if (i == 0)
                begin
                    push_pixel(1'($urandom_range(1)));
                end
                else
                begin
                    push_pixel($urandom_range(29) == 0);
                end
            end
        end
    endtask

    initial
    begin
        int goal;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = lgg_pkg::REG_START_COLOR;
        cfg_data  = '0;
        in_valid  = 1'b0;
        restart   = 1'b0;
        send_idle = 14;
        recv_idle = 86;
        sent      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frames on reset registers, first one without a restart
        push_pixel(1'b0);
        push_pixel(1'b1);

        // zero width, vertical, frame opened by an advance after frame end
        drain();
        set_frame(24'hFFFFFF, 24'h000000, 13'd0, 13'd3, 1'b1);
        repeat (3) push_pixel(1'b0);

        // stop mid-frame, then change registers before finishing it
        drain();
        set_frame(24'h000000, 24'hFFFFFF, 13'd3, 13'd2, 1'b0);
        push_pixel(1'b1);
        repeat (3) push_pixel(1'b0);
        drain();
        set_frame(24'hFFFFFF, 24'h000000, 13'h1FFF, 13'd0, 1'b0);
        repeat (2) push_pixel(1'b0);
        repeat (3) push_pixel(1'b0);
        push_pixel(1'b1);

        drain();
        set_frame(24'h00FF80, 24'hFF0080, 13'd1, 13'd4096, 1'b1);
        push_pixel(1'b1);
        repeat (3) push_pixel(1'b0);

        drain();
        set_frame(24'h000000, 24'hFFFFFF, 13'd4096, 13'd4096, 1'b0);
        push_pixel(1'b1);
        repeat (2) push_pixel(1'b0);

        for (int p = 0; p < 3; p++)
        begin
            if (p == 1)
            begin
                send_idle = 86;
                recv_idle = 14;
            end
            else if (p == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            goal = sent + RANDOM_ITEMS / 3;
            while (sent < goal)
            begin
                random_run();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
